### src/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared constants, types and round functions of the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned BlkWords = 16;
  localparam int unsigned WordAw   = 4;

  localparam logic [31:0] ChainInit0 = 32'h67452301;
  localparam logic [31:0] ChainInit1 = 32'hefcdab89;
  localparam logic [31:0] ChainInit2 = 32'h98badcfe;
  localparam logic [31:0] ChainInit3 = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLen,
    StRound,
    StFinal,
    StOut
  } md5_state_e;

  typedef logic [31:0] word_t;

  // Round constants.
  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Message word used by round r.
  function automatic logic [3:0] msg_sel(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(5 * r[3:0] + 1);
      2'd2:    g = 4'(3 * r[3:0] + 5);
      default: g = 4'(7 * r[3:0]);
    endcase
    return g;
  endfunction

  // Rotate amount of round r.
  function automatic logic [4:0] rot_sel(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
      4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

### src/md5_ram.sv
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// One MD5 round step: mixes a, b, c, d with a message word and constant.
// ----------------------------------------------------------------------------
module md5_round (
  input  logic [5:0]          round_i,
  input  md5_pkg::word_t      a_i,
  input  md5_pkg::word_t      b_i,
  input  md5_pkg::word_t      c_i,
  input  md5_pkg::word_t      d_i,
  input  md5_pkg::word_t      w_i,
  output md5_pkg::word_t      b_o
);
  import md5_pkg::*;

  word_t      f;
  word_t      sum;
  logic [4:0] s;
  logic [63:0] dbl;

  // Boolean function per phase.
  always_comb begin
    case (round_i[5:4])
      2'd0:    f = (b_i & c_i) | (~b_i & d_i);
      2'd1:    f = (b_i & d_i) | (c_i & ~d_i);
      2'd2:    f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
  end

  assign sum = a_i + f + round_k(round_i) + w_i;
  assign s   = rot_sel(round_i);
  assign dbl = {sum, sum} << s;
  assign b_o = b_i + dbl[63:32];

endmodule

### src/md5_digest_engine.sv
// ----------------------------------------------------------------------------
// md5_digest_engine
// MD5 digest over a byte stream; block buffer held in a word RAM.
// ----------------------------------------------------------------------------
// channel | dir | handshake                | payload
// in      | in  | in_valid_i / in_stall_o  | data_byte_i, byte_valid_i, last_i
// out     | out | out_valid_o / out_stall_i| digest_low_o, digest_high_o
//
// A data item that neither fills the block nor is last causes no stall.
// The 64th byte of a block starts 64 rounds, one round per cycle, paced
// by the single read port of the block RAM. A last item adds padding at
// one byte per cycle (up to 64 plus 8 length bytes) and one or two blocks.
// Reset restores the chaining words and clears the byte and bit counts.
// in_stall_o is high while a block or padding runs or a digest is unread.
module md5_digest_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_low_o,
  output logic [63:0] digest_high_o
);
  import md5_pkg::*;

  md5_state_e  state_q, state_d;
  word_t       h_q [4];
  word_t       a_q, b_q, c_q, d_q;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, len_q;
  logic [5:0]  rnd_q;
  logic        run_q;     // rounds running; low during the priming read
  logic [2:0]  lcnt_q;
  logic        pend_q;    // message ended, padding still to finish
  logic        zero_q;    // 0x80 already pushed, further pad bytes are zero
  logic [23:0] part_q;    // bytes 0..2 of the word being assembled
  logic        fin_q;     // last block of message

  // Byte push control.
  logic       push;
  logic [7:0] push_byte;
  logic       accept;
  logic       blk_full;

  // RAM port signals.
  logic              we;
  logic [WordAw-1:0] raddr;
  word_t             rdata, wdata, b_new;

  md5_ram #(.Width(32), .Depth(BlkWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[5:2]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  md5_round u_round (
    .round_i (rnd_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .c_i     (c_q),
    .d_i     (d_q),
    .w_i     (rdata),
    .b_o     (b_new)
  );

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign wdata      = {push_byte, part_q};
  assign we         = push && (fill_q[1:0] == 2'd3);
  assign fill_d     = fill_q + 6'd1;
  assign blk_full   = push && (fill_q == 6'd63);
  // Priming step reads the word of round 0, each round reads the next one.
  assign raddr      = msg_sel(rnd_q + {5'd0, run_q});

  // Byte source per state.
  always_comb begin
    push      = 1'b0;
    push_byte = data_byte_i;
    case (state_q)
      StIdle: push = accept && byte_valid_i;
      StPad: begin
        push      = 1'b1;
        push_byte = zero_q ? 8'h00 : PadByte;
      end
      StLen: begin
        push      = 1'b1;
        push_byte = len_q[7:0];
      end
      default: push = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (blk_full) state_d = StRound;
          else if (last_i) state_d = StPad;
        end
      end
      StPad: begin
        if (fill_q == 6'd63) state_d = StRound;
        else if (fill_d == LenPos) state_d = StLen;
      end
      StLen: begin
        if (lcnt_q == 3'd7) state_d = StRound;
      end
      StRound: begin
        if (run_q && rnd_q == 6'd63) state_d = StFinal;
      end
      StFinal: begin
        if (fin_q) state_d = StOut;
        else if (pend_q) state_d = StPad;
        else state_d = StIdle;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      bits_q  <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      run_q   <= 1'b0;
      lcnt_q  <= '0;
      pend_q  <= 1'b0;
      zero_q  <= 1'b0;
      fin_q   <= 1'b0;
      part_q  <= '0;
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      h_q[0]  <= ChainInit0;
      h_q[1]  <= ChainInit1;
      h_q[2]  <= ChainInit2;
      h_q[3]  <= ChainInit3;
    end else begin
      state_q <= state_d;
      if (push) begin
        fill_q <= fill_d;
        part_q <= {push_byte, part_q[23:8]};
      end
      if (accept && byte_valid_i) bits_q <= bits_q + 64'd8;
      if (accept && last_i) begin
        len_q  <= bits_q + (byte_valid_i ? 64'd8 : 64'd0);
        pend_q <= 1'b1;
      end
      // Padding bookkeeping.
      if (state_q == StPad) zero_q <= 1'b1;
      if (state_q == StLen) begin
        len_q  <= len_q >> 8;
        lcnt_q <= lcnt_q + 3'd1;
        if (lcnt_q == 3'd7) fin_q <= 1'b1;
      end
      // Rounds: one priming step, then 64 rounds.
      if (state_q == StRound) begin
        if (!run_q) begin
          run_q <= 1'b1;
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
        end else begin
          rnd_q <= rnd_q + 6'd1;
          a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_new;
          if (rnd_q == 6'd63) run_q <= 1'b0;
        end
      end
      if (state_q == StFinal) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
      end
      if (state_q == StOut && !out_stall_i) begin
        h_q[0] <= ChainInit0;
        h_q[1] <= ChainInit1;
        h_q[2] <= ChainInit2;
        h_q[3] <= ChainInit3;
        bits_q <= '0;
        fin_q  <= 1'b0;
        pend_q <= 1'b0;
        zero_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = (state_q == StOut);
  assign digest_low_o  = {h_q[1], h_q[0]};
  assign digest_high_o = {h_q[3], h_q[2]};

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !accept) else $error("accept while busy");
  a_out_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == StFinal) else $error("bad output");
  a_fill_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> fill_q == 6'd0) else $error("fill not aligned");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_low_o)
    && $stable(digest_high_o))) else $error("digest changed while stalled");

endmodule
